// ===== rtl/core/qkr_pkg.sv =====
// Shared codes, field widths and parameter defaults for the keyed-removal queue.
package qkr_pkg;

   // Field widths that the item format fixes.
   localparam int OP_BITS     = 2;
   localparam int STATUS_BITS = 2;

   // Defaults for the top-level parameters.
   localparam int DEPTH_DEFAULT       = 16;
   localparam int KEY_BITS_DEFAULT    = 16;
   localparam int HANDLE_BITS_DEFAULT = 16;

   // Operation codes carried by an input item.
   localparam logic [OP_BITS-1:0] OP_ENQUEUE = 2'd0;
   localparam logic [OP_BITS-1:0] OP_DEQUEUE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_REMOVE  = 2'd2;

   // Status codes carried by a result item.
   localparam logic [STATUS_BITS-1:0] ST_DONE = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_NONE = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;

endpackage

// ===== rtl/core/fifo_with_keyed_removal.sv =====
// Ordered job queue with dequeue and removal of the oldest entry by requester key.
// Steps: an enqueue, or an item with nothing to take, passes the front and reply states; a
// dequeue passes the take state first; a removal first compares N entries, one per cycle on
// a single key comparator, and moves the M entries behind the match up a place.
// Throughput: one item at a time; the next is taken the cycle after its result is registered.
// Reset empties the queue at once; entry storage keeps its contents, never read unwritten.
module fifo_with_keyed_removal #(
   parameter int DEPTH       = qkr_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS    = qkr_pkg::KEY_BITS_DEFAULT,
   parameter int HANDLE_BITS = qkr_pkg::HANDLE_BITS_DEFAULT,
   localparam int CW         = $clog2(DEPTH + 1),
   localparam int REQ_BITS   = qkr_pkg::OP_BITS + HANDLE_BITS + KEY_BITS,
   localparam int REQ_W      = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS   = qkr_pkg::STATUS_BITS + 2 * HANDLE_BITS + CW + 1,
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // op, job_handle, requester_key (lowest bits first), zero padded
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // status, taken_handle, front_handle, occupancy, is_empty (lowest bits first)
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int EW = KEY_BITS + HANDLE_BITS;

   logic [qkr_pkg::OP_BITS-1:0]     req_op;
   logic [HANDLE_BITS-1:0]          req_handle;
   logic [KEY_BITS-1:0]             req_key;

   logic                            res_valid;
   logic                            res_ready;
   logic [qkr_pkg::STATUS_BITS-1:0] res_status;
   logic [HANDLE_BITS-1:0]          res_taken;
   logic [HANDLE_BITS-1:0]          res_front;
   logic [CW-1:0]                   res_count;
   logic                            res_empty;

   logic                            ram_we;
   logic [AW-1:0]                   ram_waddr;
   logic [EW-1:0]                   ram_wdata;
   logic [AW-1:0]                   ram_raddr;
   logic [EW-1:0]                   ram_rdata;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]                rsp_data_ff, rsp_data_in;

   // Unpack the incoming item.
   assign req_op     = req_tdata[qkr_pkg::OP_BITS-1:0];
   assign req_handle = req_tdata[qkr_pkg::OP_BITS +: HANDLE_BITS];
   assign req_key    = req_tdata[qkr_pkg::OP_BITS + HANDLE_BITS +: KEY_BITS];

   qkr_seq #(
      .DEPTH       (DEPTH),
      .KEY_BITS    (KEY_BITS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_op      (req_op),
      .in_handle  (req_handle),
      .in_key     (req_key),
      .out_valid  (res_valid),
      .out_ready  (res_ready),
      .out_status (res_status),
      .out_taken  (res_taken),
      .out_front  (res_front),
      .out_count  (res_count),
      .out_empty  (res_empty),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

   qkr_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Output register: a result is taken in whenever the slot is free or draining.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         rsp_data_in  = RSP_W'({res_empty, res_count, res_front, res_taken, res_status});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/core/qkr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module qkr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/qkr_seq.sv =====
// Sequencer of the queue: ring pointers, key compare unit and entry move steps.
module qkr_seq #(
   parameter int DEPTH       = qkr_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS    = qkr_pkg::KEY_BITS_DEFAULT,
   parameter int HANDLE_BITS = qkr_pkg::HANDLE_BITS_DEFAULT,
   localparam int AW         = $clog2(DEPTH),
   localparam int CW         = $clog2(DEPTH + 1),
   localparam int EW         = KEY_BITS + HANDLE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   // Incoming item.
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [qkr_pkg::OP_BITS-1:0]     in_op,
   input  logic [HANDLE_BITS-1:0]          in_handle,
   input  logic [KEY_BITS-1:0]             in_key,
   // Finished result.
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [qkr_pkg::STATUS_BITS-1:0] out_status,
   output logic [HANDLE_BITS-1:0]          out_taken,
   output logic [HANDLE_BITS-1:0]          out_front,
   output logic [CW-1:0]                   out_count,
   output logic                            out_empty,
   // Entry store, each entry is {key, handle}.
   output logic                            ram_we,
   output logic [AW-1:0]                   ram_waddr,
   output logic [EW-1:0]                   ram_wdata,
   output logic [AW-1:0]                   ram_raddr,
   input  logic [EW-1:0]                   ram_rdata
);

   localparam int SW = CW + 1;

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_TAKE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_FRONT = 3'd4;
   localparam logic [2:0] S_REPLY = 3'd5;

   logic [2:0]                      state_ff, state_in;
   logic [AW-1:0]                   head_ff, head_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [CW-1:0]                   idx_ff, idx_in;
   logic [KEY_BITS-1:0]             key_ff, key_in;
   logic [qkr_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic [HANDLE_BITS-1:0]          taken_ff, taken_in;

   logic [HANDLE_BITS-1:0] rd_handle;
   logic [KEY_BITS-1:0]    rd_key;
   logic                   key_hit;
   logic [CW-1:0]          idx_next;
   logic [CW-1:0]          idx_next2;

   // Ring position of the entry that lies off places behind the front.
   function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] head,
                                              input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      begin
         sum = SW'(head) + SW'(off);
         if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
         end
         ring_pos = sum[AW-1:0];
      end
   endfunction

   assign rd_handle = ram_rdata[HANDLE_BITS-1:0];
   assign rd_key    = ram_rdata[EW-1:HANDLE_BITS];
   assign key_hit   = (rd_key == key_ff);
   assign idx_next  = idx_ff + CW'(1);
   assign idx_next2 = idx_ff + CW'(2);

   // Next-state logic of the sequencer.
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      key_in    = key_ff;
      status_in = status_ff;
      taken_in  = taken_ff;
      ram_we    = 1'b0;
      ram_waddr = ring_pos(head_ff, count_ff);
      ram_wdata = {in_key, in_handle};
      ram_raddr = head_ff;
      in_ready  = 1'b0;
      out_valid = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               key_in    = in_key;
               taken_in  = '0;
               status_in = qkr_pkg::ST_NONE;
               idx_in    = '0;
               state_in  = S_FRONT;
               unique case (in_op)
                  qkr_pkg::OP_ENQUEUE: begin
                     if (count_ff == CW'(DEPTH)) begin
                        status_in = qkr_pkg::ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        count_in  = count_ff + CW'(1);
                        status_in = qkr_pkg::ST_DONE;
                     end
                  end
                  qkr_pkg::OP_DEQUEUE: begin
                     if (count_ff != '0) begin
                        state_in = S_TAKE;
                     end
                  end
                  qkr_pkg::OP_REMOVE: begin
                     if (count_ff != '0) begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_FRONT;
                  end
               endcase
            end
         end

         // The front entry has been read; drop it by moving the head on.
         S_TAKE: begin
            taken_in  = rd_handle;
            status_in = qkr_pkg::ST_DONE;
            head_in   = ring_pos(head_ff, CW'(1));
            count_in  = count_ff - CW'(1);
            state_in  = S_FRONT;
         end

         // One entry compared per cycle while the next one is being read.
         S_SCAN: begin
            ram_raddr = ring_pos(head_ff, idx_next);
            if (key_hit) begin
               taken_in  = rd_handle;
               status_in = qkr_pkg::ST_DONE;
               if (idx_next == count_ff) begin
                  count_in = count_ff - CW'(1);
                  state_in = S_FRONT;
               end else begin
                  state_in = S_SHIFT;
               end
            end else if (idx_next == count_ff) begin
               state_in = S_FRONT;
            end else begin
               idx_in = idx_next;
            end
         end

         // Entries behind the removed one move up a place, one per cycle.
         S_SHIFT: begin
            ram_we    = 1'b1;
            ram_waddr = ring_pos(head_ff, idx_ff);
            ram_wdata = ram_rdata;
            ram_raddr = ring_pos(head_ff, idx_next2);
            if (idx_next2 == count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = S_FRONT;
            end else begin
               idx_in = idx_next;
            end
         end

         S_FRONT: begin
            state_in = S_REPLY;
         end

         S_REPLY: begin
            out_valid = 1'b1;
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Working registers of the item in progress.
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      taken_ff  <= taken_in;
   end

   // Result fields; the front entry is held on the read port in the reply state.
   assign out_status = status_ff;
   assign out_taken  = taken_ff;
   assign out_front  = (count_ff == '0) ? '0 : rd_handle;
   assign out_count  = count_ff;
   assign out_empty  = (count_ff == '0);

endmodule
